[design/aeps_pkg.sv]
// ----------------------------------------------------------------------------
// aeps_pkg
// Shared types and constants for the active/expired priority scheduler.
// ----------------------------------------------------------------------------
package aeps_pkg;

    localparam logic [3:0] MAX_PRIORITY = 4'd10;

    typedef enum logic [1:0] {
        FN_PICK      = 2'd0,
        FN_SET_READY = 2'd1,
        FN_SET_PRIO  = 2'd2,
        FN_SET_ID    = 2'd3
    } t_func;

    typedef enum logic [1:0] {
        ST_OK        = 2'd0,
        ST_BAD_PRIO  = 2'd1,
        ST_NOT_FOUND = 2'd2
    } t_status;

    // Search token that walks down the row of cells, one cell per cycle.
    typedef struct packed {
        logic        valid;
        t_func       func;
        logic [15:0] task_id;
        logic [3:0]  new_prio;
        logic        prio_bad;
        logic        found;
        logic [3:0]  best_prio;
        logic        matched;
    } t_token;

    // Commands broadcast from the controller to every cell.
    typedef struct packed {
        logic        wr_valid;
        t_func       func;
        logic [5:0]  slot;
        logic [15:0] task_id;
        logic        ready_flag;
        logic        grant_valid;
        logic        active_sel;
    } t_cmd;

endpackage

[design/aeps_if.sv]
// ----------------------------------------------------------------------------
// aeps_req_if / aeps_rsp_if
// Valid/ready channels carrying scheduler requests and responses.
// ----------------------------------------------------------------------------
interface aeps_req_if;
    logic        valid;
    logic        ready;
    logic [1:0]  func;
    logic [5:0]  slot;
    logic [15:0] task_id;
    logic [3:0]  new_priority;
    logic        ready_flag;

    modport source (output valid, func, slot, task_id, new_priority, ready_flag,
                    input ready);
    modport sink   (input valid, func, slot, task_id, new_priority, ready_flag,
                    output ready);
endinterface

interface aeps_rsp_if;
    logic        valid;
    logic        ready;
    logic [1:0]  status;
    logic        granted;
    logic [5:0]  grant_slot;
    logic        lists_swapped;

    modport source (output valid, status, granted, grant_slot, lists_swapped,
                    input ready);
    modport sink   (input valid, status, granted, grant_slot, lists_swapped,
                    output ready);
endinterface

[design/aeps_cell.sv]
// ----------------------------------------------------------------------------
// aeps_cell
// One task table entry plus one stage of the search token chain.
// ----------------------------------------------------------------------------
module aeps_cell
    import aeps_pkg::*;
#(
    parameter int IW  = 6,
    parameter int IDX = 0
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  t_cmd          i_cmd,
    input  logic [IW-1:0] i_grant_idx,
    input  t_token        i_tok,
    input  logic [IW-1:0] i_idx,
    output t_token        o_tok,
    output logic [IW-1:0] o_idx
);

    logic [15:0]   r_id, n_id;
    logic          r_ready, n_ready;
    logic [3:0]    r_prio, n_prio;
    logic          r_list, n_list;
    t_token        r_tok, n_tok;
    logic [IW-1:0] r_idx, n_idx;

    always_comb begin
        n_id    = r_id;
        n_ready = r_ready;
        n_prio  = r_prio;
        n_list  = r_list;
        n_tok   = i_tok;
        n_idx   = i_idx;

        if (i_cmd.wr_valid && int'(i_cmd.slot) == IDX) begin
            case (i_cmd.func)
                FN_SET_READY: n_ready = i_cmd.ready_flag;
                FN_SET_ID: begin
                    n_id = i_cmd.task_id;
                    if (i_cmd.task_id == 16'd0) begin
                        n_ready = 1'b0;
                    end
                end
                default: ;
            endcase
        end

        if (i_cmd.grant_valid && i_grant_idx == IW'(IDX)) begin
            n_ready = 1'b0;
            n_list  = ~i_cmd.active_sel;
        end

        if (i_tok.valid) begin
            case (i_tok.func)
                FN_PICK: begin
                    if (r_ready && r_list == i_cmd.active_sel &&
                        (!i_tok.found || r_prio < i_tok.best_prio)) begin
                        n_tok.found     = 1'b1;
                        n_tok.best_prio = r_prio;
                        n_idx           = IW'(IDX);
                    end
                end
                FN_SET_PRIO: begin
                    // Only the first matching entry along the row takes the priority.
                    if (!i_tok.prio_bad && !i_tok.matched && r_id == i_tok.task_id) begin
                        n_tok.matched = 1'b1;
                        n_prio        = i_tok.new_prio;
                    end
                end
                default: ;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_id      <= '0;
            r_ready   <= 1'b0;
            r_prio    <= '0;
            r_list    <= 1'b0;
            r_tok.valid <= 1'b0;
        end else begin
            r_id      <= n_id;
            r_ready   <= n_ready;
            r_prio    <= n_prio;
            r_list    <= n_list;
            r_tok     <= n_tok;
        end
    end

    always_ff @(posedge i_clk) begin
        r_idx           <= n_idx;
    end

    assign o_tok = r_tok;
    assign o_idx = r_idx;

endmodule

[design/active_expired_priority_scheduler.sv]
// ----------------------------------------------------------------------------
// active_expired_priority_scheduler
// Priority scheduler with active and expired lists over a row of task cells.
// ----------------------------------------------------------------------------
// The block handles one request at a time. A set-ready or set-id request
// goes from the accepted beat through the done state into the output
// register. A pick or a set-priority request sends a search token down the
// row of SLOTS cells, one cell per cycle, and its response is worked out
// when the token leaves the last cell. The next request beat is taken as
// soon as the previous response has been placed in the output register,
// even while that response still waits to be taken. After reset the table
// is empty and list 0 is the active list; no clearing pass is needed.
module active_expired_priority_scheduler
    import aeps_pkg::*;
#(
    parameter int SLOTS = 64
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    aeps_req_if.sink   i_req,
    aeps_rsp_if.source o_rsp
);

    localparam int IW = (SLOTS > 1) ? $clog2(SLOTS) : 1;

    // Controller states, one-hot.
    typedef enum logic [2:0] {
        SM_IDLE = 3'b001,
        SM_SCAN = 3'b010,
        SM_DONE = 3'b100
    } t_state;

    t_state        r_state, n_state;
    logic          r_active, n_active;

    // Pending response, held until the output register is free.
    logic [1:0]    r_res_status, n_res_status;
    logic          r_res_granted, n_res_granted;
    logic [5:0]    r_res_slot, n_res_slot;
    logic          r_res_swapped, n_res_swapped;

    // Output register.
    logic          r_out_valid, n_out_valid;
    logic [1:0]    r_out_status, n_out_status;
    logic          r_out_granted, n_out_granted;
    logic [5:0]    r_out_slot, n_out_slot;
    logic          r_out_swapped, n_out_swapped;

    t_token        w_tok [SLOTS+1];
    logic [IW-1:0] w_idx [SLOTS+1];
    t_cmd          w_cmd;

    logic          w_accept;
    t_func         w_func;
    t_token        w_last;
    logic          w_scan_end;
    logic          w_out_free;

    assign w_func     = t_func'(i_req.func);
    assign i_req.ready = (r_state == SM_IDLE);
    assign w_accept   = i_req.valid && i_req.ready;
    assign w_last     = w_tok[SLOTS];
    assign w_scan_end = (r_state == SM_SCAN) && w_last.valid;
    assign w_out_free = !r_out_valid || o_rsp.ready;

    // The search token enters the first cell in the cycle its request beat
    // is accepted. Only picks and priority updates need a pass along the row.
    always_comb begin
        w_tok[0].valid     = w_accept && (w_func == FN_PICK || w_func == FN_SET_PRIO);
        w_tok[0].func      = w_func;
        w_tok[0].task_id   = i_req.task_id;
        w_tok[0].new_prio  = i_req.new_priority;
        w_tok[0].prio_bad  = (i_req.new_priority > MAX_PRIORITY);
        w_tok[0].found     = 1'b0;
        w_tok[0].best_prio = '0;
        w_tok[0].matched   = 1'b0;
        w_idx[0]           = '0;
    end

    // Direct slot writes go straight to the addressed cell; a grant found at
    // the end of a pick pass goes back to the winning cell.
    always_comb begin
        w_cmd.wr_valid    = w_accept && (w_func == FN_SET_READY || w_func == FN_SET_ID);
        w_cmd.func        = w_func;
        w_cmd.slot        = i_req.slot;
        w_cmd.task_id     = i_req.task_id;
        w_cmd.ready_flag  = i_req.ready_flag;
        w_cmd.grant_valid = w_scan_end && w_last.func == FN_PICK && w_last.found;
        w_cmd.active_sel  = r_active;
    end

    for (genvar g = 0; g < SLOTS; g++) begin : g_cell
        aeps_cell #(
            .IW  (IW),
            .IDX (g)
        ) u_cell (
            .i_clk       (i_clk),
            .i_rst_n     (i_rst_n),
            .i_cmd       (w_cmd),
            .i_grant_idx (w_idx[SLOTS]),
            .i_tok       (w_tok[g]),
            .i_idx       (w_idx[g]),
            .o_tok       (w_tok[g+1]),
            .o_idx       (w_idx[g+1])
        );
    end

    always_comb begin
        n_state       = r_state;
        n_active      = r_active;
        n_res_status  = r_res_status;
        n_res_granted = r_res_granted;
        n_res_slot    = r_res_slot;
        n_res_swapped = r_res_swapped;
        n_out_valid   = r_out_valid;
        n_out_status  = r_out_status;
        n_out_granted = r_out_granted;
        n_out_slot    = r_out_slot;
        n_out_swapped = r_out_swapped;

        if (r_out_valid && o_rsp.ready) begin
            n_out_valid = 1'b0;
        end

        case (r_state)
            SM_IDLE: begin
                if (w_accept) begin
                    n_res_status  = ST_OK;
                    n_res_granted = 1'b0;
                    n_res_slot    = '0;
                    n_res_swapped = 1'b0;
                    if (w_func == FN_PICK || w_func == FN_SET_PRIO) begin
                        n_state = SM_SCAN;
                    end else begin
                        n_state = SM_DONE;
                    end
                end
            end
            SM_SCAN: begin
                if (w_last.valid) begin
                    n_state = SM_DONE;
                    if (w_last.func == FN_PICK) begin
                        if (w_last.found) begin
                            n_res_granted = 1'b1;
                            n_res_slot    = 6'(w_idx[SLOTS]);
                        end else begin
                            // Nothing runnable in the active list: swap roles.
                            n_active      = ~r_active;
                            n_res_swapped = 1'b1;
                        end
                    end else if (w_last.prio_bad) begin
                        n_res_status = ST_BAD_PRIO;
                    end else if (!w_last.matched) begin
                        n_res_status = ST_NOT_FOUND;
                    end
                end
            end
            SM_DONE: begin
                if (w_out_free) begin
                    n_out_valid   = 1'b1;
                    n_out_status  = r_res_status;
                    n_out_granted = r_res_granted;
                    n_out_slot    = r_res_slot;
                    n_out_swapped = r_res_swapped;
                    n_state       = SM_IDLE;
                end
            end
            default: n_state = SM_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= SM_IDLE;
            r_active    <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_active    <= n_active;
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_res_status  <= n_res_status;
        r_res_granted <= n_res_granted;
        r_res_slot    <= n_res_slot;
        r_res_swapped <= n_res_swapped;
        r_out_status  <= n_out_status;
        r_out_granted <= n_out_granted;
        r_out_slot    <= n_out_slot;
        r_out_swapped <= n_out_swapped;
    end

    assign o_rsp.valid         = r_out_valid;
    assign o_rsp.status        = r_out_status;
    assign o_rsp.granted       = r_out_granted;
    assign o_rsp.grant_slot    = r_out_slot;
    assign o_rsp.lists_swapped = r_out_swapped;

endmodule

[design/aeps_checker.sv]
// ----------------------------------------------------------------------------
// aeps_checker
// Port-level checks for the active/expired priority scheduler.
// ----------------------------------------------------------------------------
module aeps_checker
    import aeps_pkg::*;
(
    input logic       i_clk,
    input logic       i_rst_n,
    input logic       i_req_valid,
    input logic       i_req_ready,
    input logic       i_rsp_valid,
    input logic       i_rsp_ready,
    input logic [1:0] i_rsp_status,
    input logic       i_rsp_granted,
    input logic [5:0] i_rsp_grant_slot,
    input logic       i_rsp_swapped
);

    // A response beat that is not taken stays offered.
    a_rsp_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_rsp_valid && !i_rsp_ready |=> i_rsp_valid)
        else $error("response dropped before it was taken");

    // One request is in flight at a time.
    a_one_in_flight: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_req_valid && i_req_ready |=> !i_req_ready)
        else $error("second request taken while one is in flight");

    // A pick either grants or swaps the lists, never both.
    a_grant_or_swap: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_rsp_valid |-> !(i_rsp_granted && i_rsp_swapped))
        else $error("grant and list swap in the same response");

    // Error statuses only come from priority updates, which never grant.
    a_error_no_grant: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_rsp_valid && i_rsp_status != ST_OK |-> !i_rsp_granted && !i_rsp_swapped
            && i_rsp_grant_slot == 6'd0)
        else $error("error status carries pick results");

endmodule

bind active_expired_priority_scheduler aeps_checker u_aeps_checker (
    .i_clk            (i_clk),
    .i_rst_n          (i_rst_n),
    .i_req_valid      (i_req.valid),
    .i_req_ready      (i_req.ready),
    .i_rsp_valid      (o_rsp.valid),
    .i_rsp_ready      (o_rsp.ready),
    .i_rsp_status     (o_rsp.status),
    .i_rsp_granted    (o_rsp.granted),
    .i_rsp_grant_slot (o_rsp.grant_slot),
    .i_rsp_swapped    (o_rsp.lists_swapped)
);

[tb/active_expired_priority_scheduler_checker.sv]
// ----------------------------------------------------------------------------
// active_expired_priority_scheduler_checker
// Watches the request and response channels of the scheduler. It keeps its
// own copy of the task table, works out the response to each accepted request
// beat and compares every response beat with the oldest one still awaited.
// ----------------------------------------------------------------------------
module active_expired_priority_scheduler_checker
    import aeps_pkg::*;
#(
    parameter int SLOTS = 64
) (
    input  logic i_clk,
    input  logic i_rst_n,
    aeps_req_if  i_req_mon,
    aeps_rsp_if  i_rsp_mon,
    output int   o_fail_count,
    output int   o_outstanding
);
    timeunit 1ns;
    timeprecision 1ps;

    typedef struct packed {
        t_status    status;
        logic       granted;
        logic [5:0] grant_slot;
        logic       lists_swapped;
    } t_sched_result;

    // Shadow task table.
    logic [15:0] shadow_id    [SLOTS];
    logic        shadow_ready [SLOTS];
    logic [3:0]  shadow_prio  [SLOTS];
    logic        shadow_list  [SLOTS];
    logic        shadow_active;

    t_sched_result awaited_results[$];
    int            mismatches      = 0;
    int            pending_results = 0;

    assign o_fail_count  = mismatches;
    assign o_outstanding = pending_results;

    // Applies one request to the shadow table and returns the response it
    // should produce.
    function automatic t_sched_result schedule_step(t_func fn, logic [5:0] slot,
                                                    logic [15:0] id, logic [3:0] prio,
                                                    logic flag);
        t_sched_result res;
        logic          found;
        int            best;
        res   = '{status: ST_OK, granted: 1'b0, grant_slot: 6'd0, lists_swapped: 1'b0};
        found = 1'b0;
        best  = 0;
        case (fn)
            FN_PICK: begin
                for (int i = 0; i < SLOTS; i++) begin
                    if (shadow_ready[i] && shadow_list[i] == shadow_active &&
                        (!found || shadow_prio[i] < shadow_prio[best])) begin
                        best  = i;
                        found = 1'b1;
                    end
                end
                if (found) begin
                    shadow_ready[best] = 1'b0;
                    shadow_list[best]  = ~shadow_active;
                    res.granted        = 1'b1;
                    res.grant_slot     = best[5:0];
                end else begin
                    shadow_active     = ~shadow_active;
                    res.lists_swapped = 1'b1;
                end
            end
            FN_SET_READY: begin
                if (int'(slot) < SLOTS)
                    shadow_ready[slot] = flag;
            end
            FN_SET_PRIO: begin
                // The range check comes before the search, so a bad priority
                // is reported even for an id that does not exist.
                if (prio > MAX_PRIORITY) begin
                    res.status = ST_BAD_PRIO;
                end else begin
                    res.status = ST_NOT_FOUND;
                    for (int i = 0; i < SLOTS; i++) begin
                        if (res.status == ST_NOT_FOUND && shadow_id[i] == id) begin
                            shadow_prio[i] = prio;
                            res.status     = ST_OK;
                        end
                    end
                end
            end
            default: begin
                if (int'(slot) < SLOTS) begin
                    shadow_id[slot] = id;
                    if (id == 16'd0)
                        shadow_ready[slot] = 1'b0;
                end
            end
        endcase
        return res;
    endfunction

    always @(posedge i_clk) begin
        t_sched_result seen;
        t_sched_result want;
        if (!i_rst_n) begin
            for (int i = 0; i < SLOTS; i++) begin
                shadow_id[i]    = 16'd0;
                shadow_ready[i] = 1'b0;
                shadow_prio[i]  = 4'd0;
                shadow_list[i]  = 1'b0;
            end
            shadow_active = 1'b0;
            awaited_results.delete();
        end else begin
            // A response beat always belongs to an earlier request, so it is
            // retired before a request beat on the same edge is predicted.
            if (i_rsp_mon.valid && i_rsp_mon.ready) begin
                seen = '{status: t_status'(i_rsp_mon.status), granted: i_rsp_mon.granted,
                         grant_slot: i_rsp_mon.grant_slot,
                         lists_swapped: i_rsp_mon.lists_swapped};
                if (awaited_results.size() == 0) begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("%0t: unexpected response beat status=%0d granted=%0d slot=%0d swapped=%0d",
                                 $realtime, seen.status, seen.granted, seen.grant_slot,
                                 seen.lists_swapped);
                end else begin
                    want = awaited_results.pop_front();
                    if (seen.status != want.status || seen.granted != want.granted ||
                        seen.grant_slot != want.grant_slot ||
                        seen.lists_swapped != want.lists_swapped) begin
                        mismatches++;
                        if (mismatches <= 10)
                            $display("%0t: response mismatch expected status=%0d granted=%0d slot=%0d swapped=%0d, got status=%0d granted=%0d slot=%0d swapped=%0d",
                                     $realtime, want.status, want.granted, want.grant_slot,
                                     want.lists_swapped, seen.status, seen.granted,
                                     seen.grant_slot, seen.lists_swapped);
                    end
                end
            end
            if (i_req_mon.valid && i_req_mon.ready)
                awaited_results.push_back(schedule_step(t_func'(i_req_mon.func), i_req_mon.slot,
                                                        i_req_mon.task_id,
                                                        i_req_mon.new_priority,
                                                        i_req_mon.ready_flag));
        end
        pending_results = awaited_results.size();
    end

endmodule

[tb/active_expired_priority_scheduler_tb.sv]
// ----------------------------------------------------------------------------
// active_expired_priority_scheduler_tb
// Drives requests into the active/expired priority scheduler, stalls the
// response side at random and reports the verdict of the checker.
// ----------------------------------------------------------------------------
module active_expired_priority_scheduler_tb
    import aeps_pkg::*;
;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int SLOTS        = 64;
    localparam int REQUEST_BEATS = 1550;
    // Calm tail: the last requests are sent without any idling on either side.
    localparam int CALM_BEATS    = 200;
    // Several times the slowest correct run, even with the longest gaps on
    // both sides.
    localparam int unsigned CYCLE_LIMIT = 1_000_000;

    logic i_clk;
    logic i_rst_n;

    aeps_req_if req_ch ();
    aeps_rsp_if rsp_ch ();

    int fail_total;
    int results_awaited;

    // When set, neither the request side nor the response side idles.
    logic        calm;
    int          beats_sent;
    logic [15:0] id_pool [16];

    active_expired_priority_scheduler #(
        .SLOTS (SLOTS)
    ) u_top (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (req_ch),
        .o_rsp   (rsp_ch)
    );

    active_expired_priority_scheduler_checker #(
        .SLOTS (SLOTS)
    ) u_checker (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_req_mon     (req_ch),
        .i_rsp_mon     (rsp_ch),
        .o_fail_count  (fail_total),
        .o_outstanding (results_awaited)
    );

    initial i_clk = 1'b0;
    always #10 i_clk = ~i_clk;

    // Watchdog: a hung handshake ends the run here.
    int unsigned cycle_count = 0;
    always @(posedge i_clk) begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("Regression FAIL");
            $finish;
        end
    end

    // Response side. The ready line drops at random in bursts, and stays high
    // throughout the calm tail.
    initial begin
        int stall_left;
        stall_left   = 0;
        rsp_ch.ready = 1'b0;
        forever begin
            @(negedge i_clk);
            if (stall_left > 0) begin
                stall_left--;
                rsp_ch.ready = 1'b0;
            end else if (!calm && $urandom_range(0, 5) == 0) begin
                stall_left   = $urandom_range(1, 11) - 1;
                rsp_ch.ready = 1'b0;
            end else begin
                rsp_ch.ready = 1'b1;
            end
        end
    end

    // Presents one request beat from a falling edge and holds it until the
    // block takes it. Before the beat the sender may drop valid and idle at
    // random. Valid is left high on return so that back-to-back beats never
    // see it toggle.
    task automatic send_request(input t_func fn, input logic [5:0] slot,
                                input logic [15:0] id, input logic [3:0] prio,
                                input logic flag);
        if (!calm && $urandom_range(0, 4) == 0) begin
            req_ch.valid = 1'b0;
            repeat ($urandom_range(1, 11)) @(negedge i_clk);
        end
        req_ch.valid        = 1'b1;
        req_ch.func         = fn;
        req_ch.slot         = slot;
        req_ch.task_id      = id;
        req_ch.new_priority = prio;
        req_ch.ready_flag   = flag;
        do @(posedge i_clk); while (!req_ch.ready);
        @(negedge i_clk);
        beats_sent++;
    endtask

    // Ids are drawn mostly from a small pool so that set-priority requests
    // find their entries, with the odd fully random id that usually misses.
    function automatic logic [15:0] draw_task_id();
        if ($urandom_range(0, 3) == 0)
            return 16'($urandom());
        return id_pool[$urandom_range(0, 15)];
    endfunction

    function automatic logic [3:0] draw_priority();
        if ($urandom_range(0, 7) == 0)
            return 4'($urandom_range(11, 15));
        return 4'($urandom_range(0, 10));
    endfunction

    initial begin
        logic       drained_once;
        logic [5:0] slot;
        logic [15:0] id;

        req_ch.valid        = 1'b0;
        req_ch.func         = FN_PICK;
        req_ch.slot         = 6'd0;
        req_ch.task_id      = 16'd0;
        req_ch.new_priority = 4'd0;
        req_ch.ready_flag   = 1'b0;
        calm                = 1'b0;
        beats_sent          = 0;
        drained_once        = 1'b0;

        i_rst_n = 1'b0;
        repeat (9) @(negedge i_clk);
        i_rst_n = 1'b1;

        // Directed part. A pick on the empty table swaps the lists, and a
        // second one swaps them back.
        send_request(FN_PICK, 6'd0, 16'd0, 4'd0, 1'b0);
        send_request(FN_PICK, 6'd63, 16'hFFFF, 4'd15, 1'b1);
        // Extreme ids in the extreme slots.
        send_request(FN_SET_ID, 6'd0, 16'hFFFF, 4'd0, 1'b0);
        send_request(FN_SET_ID, 6'd63, 16'h8000, 4'd0, 1'b0);
        send_request(FN_SET_PRIO, 6'd0, 16'hFFFF, 4'd10, 1'b0);
        send_request(FN_SET_PRIO, 6'd0, 16'h8000, 4'd0, 1'b0);
        // Out-of-range priorities are refused before the id is looked up,
        // even for an id that is not in the table.
        send_request(FN_SET_PRIO, 6'd0, 16'h8000, 4'd11, 1'b0);
        send_request(FN_SET_PRIO, 6'd0, 16'h1234, 4'd15, 1'b0);
        // An id that nobody carries.
        send_request(FN_SET_PRIO, 6'd0, 16'h1234, 4'd3, 1'b0);
        // Id zero matches the lowest free entry, which is slot 1 here.
        send_request(FN_SET_PRIO, 6'd0, 16'h0000, 4'd5, 1'b0);
        // Make slots 0, 1, 2 and 63 runnable; slots 1 and 2 are free but ready.
        send_request(FN_SET_READY, 6'd0, 16'd0, 4'd0, 1'b1);
        send_request(FN_SET_READY, 6'd63, 16'd0, 4'd0, 1'b1);
        send_request(FN_SET_READY, 6'd1, 16'd0, 4'd0, 1'b1);
        send_request(FN_SET_READY, 6'd2, 16'd0, 4'd0, 1'b1);
        // Slots 2 and 63 tie at priority zero and the lower slot wins; then
        // slot 1 and slot 0 follow, and the fifth pick finds the list empty.
        repeat (5) send_request(FN_PICK, 6'd0, 16'd0, 4'd0, 1'b0);
        // After the swap the picked entries are in the active list again.
        send_request(FN_SET_READY, 6'd63, 16'd0, 4'd0, 1'b1);
        send_request(FN_SET_READY, 6'd0, 16'd0, 4'd0, 1'b1);
        // Freeing slot 0 also clears its ready bit, so only slot 63 is granted.
        send_request(FN_SET_ID, 6'd0, 16'h0000, 4'd0, 1'b0);
        send_request(FN_PICK, 6'd0, 16'd0, 4'd0, 1'b0);
        // Putting a slot to sleep.
        send_request(FN_SET_READY, 6'd63, 16'd0, 4'd0, 1'b0);
        send_request(FN_PICK, 6'd0, 16'd0, 4'd0, 1'b0);

        for (int i = 0; i < 16; i++)
            id_pool[i] = 16'($urandom());

        // Random part. Most of it fills slots in well-formed order (id, then
        // priority, then ready) and picks from them; the rest is scattered
        // single requests with random content in the unused fields.
        while (beats_sent < REQUEST_BEATS) begin
            if (beats_sent >= REQUEST_BEATS - CALM_BEATS)
                calm = 1'b1;
            if (!drained_once && beats_sent >= REQUEST_BEATS / 2) begin
                // Hold off until every awaited response has come back.
                drained_once = 1'b1;
                req_ch.valid = 1'b0;
                while (results_awaited != 0) @(negedge i_clk);
            end
            slot = ($urandom_range(0, 3) == 0) ? 6'($urandom()) : 6'($urandom_range(0, 15));
            case ($urandom_range(0, 9))
                0, 1: begin
                    id = draw_task_id();
                    send_request(FN_SET_ID, slot, id, 4'($urandom()), 1'($urandom()));
                    send_request(FN_SET_PRIO, 6'($urandom()), id, draw_priority(),
                                 1'($urandom()));
                    send_request(FN_SET_READY, slot, 16'($urandom()), 4'($urandom()), 1'b1);
                end
                2, 3, 4: begin
                    send_request(FN_PICK, 6'($urandom()), 16'($urandom()), 4'($urandom()),
                                 1'($urandom()));
                end
                5: begin
                    send_request(FN_SET_READY, slot, 16'($urandom()), 4'($urandom()),
                                 1'($urandom_range(0, 3) != 0));
                end
                6, 7: begin
                    send_request(FN_SET_PRIO, 6'($urandom()), draw_task_id(), draw_priority(),
                                 1'($urandom()));
                end
                default: begin
                    id = ($urandom_range(0, 4) == 0) ? 16'h0000 : draw_task_id();
                    send_request(FN_SET_ID, slot, id, 4'($urandom()), 1'($urandom()));
                end
            endcase
        end
        req_ch.valid = 1'b0;

        while (results_awaited != 0) @(negedge i_clk);
        // Let a late stray response show itself before the verdict.
        repeat (SLOTS + 8) @(negedge i_clk);

        if (fail_total == 0)
            $display("Regression PASS");
        else
            $display("Regression FAIL");
        $finish;
    end

endmodule
